@@ hdl/mt19937_ranged_random_top_defines.svh @@
// ----------------------------------------------------------------------------
// mt19937_ranged_random_top_defines
// Assertion macros for the ranged MT19937 block.
// ----------------------------------------------------------------------------
`ifndef MT19937_RANGED_RANDOM_TOP_DEFINES_SVH
`define MT19937_RANGED_RANDOM_TOP_DEFINES_SVH
// implication checked every cycle outside reset
`define MRR_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// implication checked in the next cycle
`define MRR_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

@@ hdl/mrr_pkg.sv @@
// ----------------------------------------------------------------------------
// mrr_pkg
// Types and constants shared by the ranged MT19937 generator.
// ----------------------------------------------------------------------------
`default_nettype none
package mrr_pkg;
   localparam int unsigned STATE_WORDS = 624;
   localparam int unsigned SHIFT_OFFSET = 397;
   localparam int unsigned IDX_W = 10;
   localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
   localparam logic [31:0] SEED_MULT = 32'd1812433253;
   localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C = 32'hefc60000;
   localparam logic [31:0] SEED_RESET = 32'd5489;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_ORDER = 2'd1;
   localparam logic [1:0] STATUS_SPAN = 2'd2;
   localparam logic FUNC_RAW = 1'b0;
   localparam logic FUNC_RANGED = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] range_low;
      logic [31:0] range_high;
   } req_type;

   typedef struct packed {
      logic [31:0] raw_word;
      logic [31:0] ranged_value;
      logic [1:0]  status;
   } rsp_type;

   // temper one state word
   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction
endpackage
`default_nettype wire

@@ hdl/mrr_divider.sv @@
// ----------------------------------------------------------------------------
// mrr_divider
// Bit-serial restoring remainder unit: 31-bit dividend, 32-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module mrr_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [30:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      remainder
);
   import mrr_pkg::*;

   logic [30:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in, den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;
   logic [32:0] trial, diff;

   // one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[30]};
      diff = trial - {1'b0, den_ff};
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      if (start) begin
         quo_in = dividend; rem_in = '0; den_in = divisor;
         cnt_in = 5'd30; run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[29:0], 1'b0};
         rem_in = diff[32] ? trial[31:0] : diff[31:0];
         if (cnt_ff == 5'd0) begin
            run_in = 1'b0; done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

@@ hdl/mrr_state_ram.sv @@
// ----------------------------------------------------------------------------
// mrr_state_ram
// Twister state store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none
module mrr_state_ram (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [mrr_pkg::IDX_W-1:0] wr_addr,
   input  wire logic [31:0]              wr_data,
   input  wire logic [mrr_pkg::IDX_W-1:0] rd_addr_a,
   input  wire logic [mrr_pkg::IDX_W-1:0] rd_addr_b,
   output logic [31:0]                   rd_data_a,
   output logic [31:0]                   rd_data_b
);
   import mrr_pkg::*;

   logic [31:0] mem [STATE_WORDS];

   // write, and registered reads that return the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule
`default_nettype wire

@@ hdl/mt19937_ranged_random_top.sv @@
// ----------------------------------------------------------------------------
// mt19937_ranged_random_top
// MT19937 generator with raw and inclusive ranged requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result shows
// on the rsp_ ports for one cycle with rsp_valid high and cannot be held off.
// A ranged draw waits on the bit-serial remainder unit (one bit per cycle);
// a raw draw does not. Requests that need no draw answer straight from the
// range check. The first draw after reset or a seed write first seeds the
// state (per word: the write, then the next multiplied term). That draw and
// every 624th draw after it first twist the state (per word: far word, then
// the word and its neighbor, then the write back).
`default_nettype none
`include "mt19937_ranged_random_top_defines.svh"
module mt19937_ranged_random_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mrr_pkg::req_type req_data,
   output logic                  rsp_valid,
   output mrr_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [1:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import mrr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_SEED, ST_SEED_WR, ST_TW_FAR, ST_TW_RD, ST_TW_WR,
      ST_DRAW_RD, ST_DRAW_WT, ST_DIV_WT, ST_OUT
   } state_type;

   state_type         st_ff;
   req_type           req_ff;
   rsp_type           rsp_ff;
   logic              done_ff;
   logic [31:0]       seed_ff;
   logic              pend_ff;
   logic [IDX_W-1:0]  idx_ff, k_ff;
   logic [31:0]       prev_ff, keep_ff;
   logic [31:0]       mul_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr, rd_a, rd_b;
   logic [31:0]       wr_data, rd_data_a, rd_data_b;
   logic              div_start, div_done;
   logic [31:0]       div_rem, span;
   logic [32:0]       diff;
   logic [IDX_W-1:0]  k_nxt, k_far;
   logic [31:0]       y_tw, tw_word;
   logic [31:0]       drawn_word;

   // configuration port
   assign pready = 1'b1;
   assign prdata = seed_ff;
   wire cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

   // range arithmetic
   assign diff = {req_ff.range_high[31], req_ff.range_high}
               - {req_ff.range_low[31], req_ff.range_low};
   assign span = diff[31:0] + 32'd1;

   // twist neighbors
   assign k_nxt = (k_ff == IDX_W'(STATE_WORDS - 1)) ? '0 : k_ff + IDX_W'(1);
   assign k_far = (k_ff >= IDX_W'(STATE_WORDS - SHIFT_OFFSET))
                ? k_ff - IDX_W'(STATE_WORDS - SHIFT_OFFSET)
                : k_ff + IDX_W'(SHIFT_OFFSET);
   // word k is read from port a with k+1 on b; far word was kept earlier
   assign y_tw = {rd_data_a[31], rd_data_b[30:0]};
   assign tw_word = keep_ff ^ (y_tw >> 1) ^ (y_tw[0] ? TWIST_MATRIX : 32'd0);

   always_comb begin
      wr_en = 1'b0; wr_addr = k_ff; wr_data = prev_ff;
      rd_a = k_ff; rd_b = k_nxt;
      case (st_ff)
         ST_SEED_WR: begin
            wr_en = 1'b1;
            wr_data = mul_ff + {{(32-IDX_W){1'b0}}, k_ff};
         end
         ST_TW_FAR: rd_a = k_far;
         ST_TW_WR: begin
            wr_en = 1'b1; wr_data = tw_word;
         end
         ST_DRAW_RD: rd_a = idx_ff;
         default: ;
      endcase
   end

   mrr_state_ram u_ram (
      .clock, .wr_en, .wr_addr, .wr_data,
      .rd_addr_a(rd_a), .rd_addr_b(rd_b), .rd_data_a, .rd_data_b
   );

   assign drawn_word = temper(rd_data_a);

   assign div_start = (st_ff == ST_DRAW_WT) && (req_ff.func == FUNC_RANGED);
   mrr_divider u_div (
      .clock, .reset, .start(div_start),
      .dividend(drawn_word[31:1]), .divisor(span),
      .done(div_done), .remainder(div_rem)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; done_ff <= 1'b0; pend_ff <= 1'b1;
         seed_ff <= SEED_RESET; idx_ff <= IDX_W'(STATE_WORDS);
      end else begin
         done_ff <= 1'b0;
         if (cfg_wr) begin
            seed_ff <= pwdata; pend_ff <= 1'b1;
         end
         case (st_ff)
            ST_IDLE: if (start) begin
               req_ff <= req_data; st_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (req_ff.func == FUNC_RANGED && $signed(diff) < 0) begin
                  rsp_ff <= '{32'd0, 32'd0, STATUS_ORDER}; st_ff <= ST_OUT;
               end else if (req_ff.func == FUNC_RANGED && diff == 33'd0) begin
                  rsp_ff <= '{32'd0, req_ff.range_low, STATUS_OK}; st_ff <= ST_OUT;
               end else if (req_ff.func == FUNC_RANGED && diff[31]) begin
                  rsp_ff <= '{32'd0, 32'hffffffff, STATUS_SPAN}; st_ff <= ST_OUT;
               end else begin
                  rsp_ff <= '0;
                  if (pend_ff) begin
                     prev_ff <= seed_ff; k_ff <= '0; mul_ff <= seed_ff;
                     st_ff <= ST_SEED_WR;
                  end else if (idx_ff == IDX_W'(STATE_WORDS)) begin
                     k_ff <= '0; st_ff <= ST_TW_FAR;
                  end else begin
                     st_ff <= ST_DRAW_RD;
                  end
               end
            end
            // seeding: mul_ff holds the multiplied term, k added at write
            ST_SEED_WR: begin
               prev_ff <= mul_ff + {{(32-IDX_W){1'b0}}, k_ff};
               st_ff <= ST_SEED;
            end
            ST_SEED: begin
               mul_ff <= SEED_MULT * (prev_ff ^ (prev_ff >> 30));
               if (k_ff == IDX_W'(STATE_WORDS - 1)) begin
                  pend_ff <= 1'b0; k_ff <= '0;
                  idx_ff <= '0; st_ff <= ST_TW_FAR;
               end else begin
                  k_ff <= k_ff + IDX_W'(1); st_ff <= ST_SEED_WR;
               end
            end
            // twist: read far word first, then k and k+1, write k
            ST_TW_FAR: st_ff <= ST_TW_RD;
            ST_TW_RD: begin
               keep_ff <= rd_data_a; st_ff <= ST_TW_WR;
            end
            ST_TW_WR: begin
               if (k_ff == IDX_W'(STATE_WORDS - 1)) begin
                  idx_ff <= '0; st_ff <= ST_DRAW_RD;
               end else begin
                  k_ff <= k_ff + IDX_W'(1); st_ff <= ST_TW_FAR;
               end
            end
            ST_DRAW_RD: begin
               idx_ff <= idx_ff + IDX_W'(1); st_ff <= ST_DRAW_WT;
            end
            ST_DRAW_WT: begin
               if (req_ff.func == FUNC_RANGED) begin
                  st_ff <= ST_DIV_WT;
               end else begin
                  rsp_ff.raw_word <= drawn_word; st_ff <= ST_OUT;
               end
            end
            ST_DIV_WT: if (div_done) begin
               rsp_ff.ranged_value <= req_ff.range_low + div_rem;
               st_ff <= ST_OUT;
            end
            ST_OUT: begin
               done_ff <= 1'b1; st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (st_ff != ST_IDLE);
   assign rsp_valid = done_ff;
   assign rsp_data = rsp_ff;

   `MRR_ASSERT_IMPL(a_done_idle, clock, reset, rsp_valid, !busy)
   `MRR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `MRR_ASSERT_IMPL(a_span_status, clock, reset,
      rsp_valid && rsp_data.status == STATUS_SPAN, rsp_data.ranged_value == 32'hffffffff)
   `MRR_ASSERT_IMPL(a_raw_only, clock, reset,
      rsp_valid && rsp_data.status != STATUS_OK, rsp_data.raw_word == 32'd0)
endmodule
`default_nettype wire

@@ bench/mt19937_ranged_random_top_tb.sv @@
// ----------------------------------------------------------------------------
// mt19937_ranged_random_top_tb
// Self-checking bench for the ranged MT19937 generator: a local twister model
// predicts each result, seeds are written through the register port between
// phases, and random requests with random gaps exercise raw and ranged draws.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Twister model and expected-result store
class twister_scoreboard;
   logic [31:0] words [624];
   int unsigned word_idx;
   bit          reseed_due;
   logic [31:0] seed_word;
   mrr_pkg::rsp_type pending_rsp [$];
   int unsigned fail_count;

   function void clear();
      foreach (words[i]) words[i] = '0;
      word_idx   = mrr_pkg::STATE_WORDS;
      reseed_due = 1'b1;
      seed_word  = mrr_pkg::SEED_RESET;
      pending_rsp.delete();
      fail_count = 0;
   endfunction

   function void set_seed(logic [31:0] s);
      seed_word  = s;
      reseed_due = 1'b1;
   endfunction

   // Pull one tempered word, reseeding and twisting as needed
   function logic [31:0] next_word();
      logic [31:0] y;
      logic [31:0] p;
      int unsigned nxt;
      int unsigned far;
      if (reseed_due) begin
         words[0] = seed_word;
         for (int i = 1; i < 624; i++) begin
            p = words[i-1];
            words[i] = mrr_pkg::SEED_MULT * (p ^ (p >> 30)) + i;
         end
         word_idx   = mrr_pkg::STATE_WORDS;
         reseed_due = 1'b0;
      end
      if (word_idx >= mrr_pkg::STATE_WORDS) begin
         for (int k = 0; k < 624; k++) begin
            nxt = (k + 1) % 624;
            far = (k + mrr_pkg::SHIFT_OFFSET) % 624;
            y = (words[k] & 32'h80000000) | (words[nxt] & 32'h7fffffff);
            words[k] = words[far] ^ (y >> 1) ^ (y[0] ? mrr_pkg::TWIST_MATRIX : 32'h0);
         end
         word_idx = 0;
      end
      y = words[word_idx];
      word_idx++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & mrr_pkg::TEMPER_B);
      y = y ^ ((y << 15) & mrr_pkg::TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // Note an accepted request and queue its expected result
   function void note_request(mrr_pkg::req_type rq);
      mrr_pkg::rsp_type r;
      longint lo;
      longint hi;
      longint unsigned span;
      logic [31:0] n;
      r = '0;
      if (rq.func == mrr_pkg::FUNC_RAW) begin
         r.raw_word = next_word();
      end else begin
         lo = longint'($signed(rq.range_low));
         hi = longint'($signed(rq.range_high));
         if (hi < lo) begin
            r.status = mrr_pkg::STATUS_ORDER;
         end else if (hi == lo) begin
            r.ranged_value = rq.range_low;
         end else begin
            span = longint'(hi - lo);
            if (span > 64'h7fffffff) begin
               r.ranged_value = 32'hffffffff;
               r.status = mrr_pkg::STATUS_SPAN;
            end else begin
               n = next_word() >> 1;
               r.ranged_value = rq.range_low + 32'(longint'(n) % (span + 1));
            end
         end
      end
      pending_rsp.push_back(r);
   endfunction

   // Compare one result against the oldest expectation
   function void check_result(mrr_pkg::rsp_type got);
      mrr_pkg::rsp_type exp_rsp;
      if (pending_rsp.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         fail_count++;
         return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (got.raw_word !== exp_rsp.raw_word) begin
         $display("%0t: raw_word exp %h got %h", $time, exp_rsp.raw_word, got.raw_word);
         fail_count++;
      end
      if (got.ranged_value !== exp_rsp.ranged_value) begin
         $display("%0t: ranged_value exp %h got %h", $time, exp_rsp.ranged_value,
                  got.ranged_value);
         fail_count++;
      end
      if (got.status !== exp_rsp.status) begin
         $display("%0t: status exp %0d got %0d", $time, exp_rsp.status, got.status);
         fail_count++;
      end
   endfunction
endclass

module mt19937_ranged_random_top_tb;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam logic [1:0] SEED_ADDR = 2'd0;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   mrr_pkg::req_type req_data;
   logic rsp_valid;
   mrr_pkg::rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   twister_scoreboard sb;
   longint cycle_count;

   mt19937_ranged_random_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check every result strobe; enforce the run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid === 1'b1) sb.check_result(rsp_data);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Hold off for a random gap, mostly short
   task automatic idle_gap();
      int unsigned n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      repeat (n) @(posedge clock);
   endtask

   // Issue one request and note it at acceptance
   task automatic send_request(mrr_pkg::req_type rq);
      start    <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_request(rq);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_fields(logic f, logic [31:0] lo, logic [31:0] hi);
      mrr_pkg::req_type rq;
      rq.func = f;
      rq.range_low = lo;
      rq.range_high = hi;
      send_request(rq);
   endtask

   // Wait until nothing is expected, then let the block settle
   task automatic drain();
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Write the seed register (setup then access)
   task automatic write_seed(logic [31:0] s);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= SEED_ADDR; pwdata <= s;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      sb.set_seed(s);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Random request: mostly raw draws and valid ranges, some edge and error cases
   task automatic random_request();
      logic [31:0] lo;
      logic [31:0] hi;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      lo = $urandom();
      hi = $urandom();
      if (pick < 40) begin
         send_fields(mrr_pkg::FUNC_RAW, lo, hi);
      end else if (pick < 60) begin
         hi = lo + $urandom_range(1, 1000);
         if ($signed(hi) < $signed(lo)) hi = 32'h7fffffff;
         if (hi == lo) lo = lo - 1;
         send_fields(mrr_pkg::FUNC_RANGED, lo, hi);
      end else if (pick < 75) begin
         lo = $signed(lo) >>> 1;
         hi = lo + ($urandom() >> 1);
         if ($signed(hi) < $signed(lo)) hi = 32'h7fffffff;
         send_fields(mrr_pkg::FUNC_RANGED, lo, hi);
      end else if (pick < 80) begin
         send_fields(mrr_pkg::FUNC_RANGED, lo, lo);
      end else begin
         send_fields(mrr_pkg::FUNC_RANGED, lo, hi);
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      cycle_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: no-draw cases first leave the reseed pending
      send_fields(mrr_pkg::FUNC_RANGED, 32'd10, 32'd5);
      send_fields(mrr_pkg::FUNC_RANGED, 32'h80000000, 32'h7fffffff);
      send_fields(mrr_pkg::FUNC_RANGED, 32'h7fffffff, 32'h7fffffff);
      send_fields(mrr_pkg::FUNC_RANGED, 32'h80000000, 32'h80000000);
      send_fields(mrr_pkg::FUNC_RAW, 32'hffffffff, 32'hffffffff);
      send_fields(mrr_pkg::FUNC_RAW, 32'h0, 32'h0);
      send_fields(mrr_pkg::FUNC_RANGED, 32'h0, 32'h7fffffff);
      send_fields(mrr_pkg::FUNC_RANGED, 32'hffffffff, 32'h7ffffffe);
      send_fields(mrr_pkg::FUNC_RANGED, 32'hffffffff, 32'h7fffffff);
      send_fields(mrr_pkg::FUNC_RANGED, 32'h80000000, 32'hffffffff);
      send_fields(mrr_pkg::FUNC_RANGED, 32'h7fffffff, 32'h80000000);
      send_fields(mrr_pkg::FUNC_RANGED, 32'hfffffffe, 32'h0);
      send_fields(mrr_pkg::FUNC_RANGED, 32'd0, 32'd1);
      drain();

      // Seed extremes; a no-draw request keeps the reseed pending
      write_seed(32'h0);
      send_fields(mrr_pkg::FUNC_RANGED, 32'd3, 32'd3);
      send_fields(mrr_pkg::FUNC_RAW, 32'h0, 32'h0);
      drain();
      write_seed(32'hffffffff);
      send_fields(mrr_pkg::FUNC_RAW, 32'h0, 32'h0);
      send_fields(mrr_pkg::FUNC_RANGED, 32'hffffff00, 32'h100);
      drain();

      // Random phases with a different seed each
      for (int ph = 0; ph < 4; ph++) begin
         write_seed(ph == 3 ? mrr_pkg::SEED_RESET : $urandom());
         for (int i = 0; i < 385; i++) begin
            random_request();
            if ($urandom_range(0, 3) != 0) idle_gap();
            if (i == 200) drain();
         end
         drain();
      end

      if (sb.fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/mrr_pkg.sv
hdl/mrr_divider.sv
hdl/mrr_state_ram.sv
hdl/mt19937_ranged_random_top.sv
bench/mt19937_ranged_random_top_tb.sv
